/* design/ffca_pkg.sv */
// ffca_pkg: constants, node record and codes for the first-fit chunk allocator.
// No dependencies; imported by every other design file.
`default_nettype none
package ffca_pkg;

  localparam int MAX_NODES      = 256;
  localparam int HEADER_BYTES   = 16;
  localparam int ADDR_BITS      = 20;
  localparam int MIN_SPLIT_DATA = 8;

  localparam int IDX_W  = $clog2(MAX_NODES);
  localparam int NEXT_W = $clog2(MAX_NODES + 1);
  localparam int SIZE_W = 21;

  localparam logic [NEXT_W-1:0] END_MARK    = NEXT_W'(MAX_NODES);
  localparam logic [SIZE_W-1:0] HDR_SZ      = SIZE_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] SPLIT_MIN   = SIZE_W'(HEADER_BYTES + MIN_SPLIT_DATA);
  localparam logic [SIZE_W-1:0] ARENA_LIMIT = SIZE_W'(64'd1 << ADDR_BITS);
  localparam logic [SIZE_W-1:0] HEAD_RESET  = ARENA_LIMIT - HDR_SZ;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [2:0] {
    STATUS_OK          = 3'd0,
    STATUS_OOM         = 3'd1,
    STATUS_NULL        = 3'd2,
    STATUS_NOT_FOUND   = 3'd3,
    STATUS_PARTIAL     = 3'd4,
    STATUS_DOUBLE_FREE = 3'd5
  } status_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] offset;
    logic [SIZE_W-1:0]    size;
    logic                 used;
    logic [NEXT_W-1:0]    next;
  } node_t;

endpackage
`default_nettype wire

/* design/ffca_if.sv */
// ffca_in_if / ffca_out_if: valid/ready channels for commands and results.
// Depends on ffca_pkg for field widths.
`default_nettype none
interface ffca_in_if;
  import ffca_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [SIZE_W-1:0]    request_size;
  logic [ADDR_BITS-1:0] pointer_offset;
  logic                 pointer_is_null;

  modport source (output valid, cmd, request_size, pointer_offset, pointer_is_null,
                  input ready);
  modport sink   (input valid, cmd, request_size, pointer_offset, pointer_is_null,
                  output ready);
endinterface

interface ffca_out_if;
  import ffca_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [2:0]           status;
  logic [ADDR_BITS-1:0] data_offset;

  modport source (output valid, status, data_offset, input ready);
  modport sink   (input valid, status, data_offset, output ready);
endinterface
`default_nettype wire

/* design/ffca_node_ram.sv */
// ffca_node_ram: chunk node table, one write port and one registered read port.
// Depends on ffca_pkg (node_t, MAX_NODES).
`default_nettype none
module ffca_node_ram
  import ffca_pkg::*;
(
  input  wire             clk,
  input  wire             we,
  input  wire [IDX_W-1:0] waddr,
  input  wire node_t      wdata,
  input  wire [IDX_W-1:0] raddr,
  output node_t           rdata
);

  node_t mem [MAX_NODES];
  node_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* design/first_fit_chunk_allocator.sv */
// first_fit_chunk_allocator: list walker, node updates and result register.
// Depends on ffca_pkg, ffca_if (channels) and ffca_node_ram.
//
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid/ready   | cmd, request_size, pointer_offset, pointer_is_null
//  out_ch  | out | valid/ready   | status, data_offset
//  cfg     | in  | cfg_wr_en     | cfg_wr_data (arena length)
//
// A walk visits N chunks (1..MAX_NODES), following next pointers through the
// node RAM, one node per cycle, using its registered read port. Split
// allocations write the current node, then the new node. Null frees skip the
// walk. Reset and arena length writes rebuild the list at once (head node held
// in registers until first written); no clearing pass.
// in_ch.ready is high only when idle; a result waits in the output register.
`default_nettype none
module first_fit_chunk_allocator
  import ffca_pkg::*;
(
  input  wire               clk,
  input  wire               rst_n,
  ffca_in_if.sink           in_ch,
  ffca_out_if.source        out_ch,
  input  wire               cfg_wr_en,
  input  wire [SIZE_W-1:0]  cfg_wr_data
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_WALK   = 5'b00010,
    ST_WR_CUR = 5'b00100,
    ST_WR_NEW = 5'b01000,
    ST_RESP   = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [NEXT_W-1:0]    cnt_r, cnt_nxt;
  logic                 fresh_r, fresh_nxt;
  logic [SIZE_W-1:0]    head_size_r, head_size_nxt;
  logic [IDX_W-1:0]     cur_r, cur_nxt;
  logic                 cmd_r, cmd_nxt;
  logic [SIZE_W-1:0]    req_r, req_nxt;
  logic [ADDR_BITS-1:0] ptr_r, ptr_nxt;
  logic                 split_r, split_nxt;
  node_t                wcur_r, wcur_nxt;
  node_t                wnew_r, wnew_nxt;
  status_t              res_status_r, res_status_nxt;
  logic [ADDR_BITS-1:0] res_off_r, res_off_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [2:0]           out_status_r, out_status_nxt;
  logic [ADDR_BITS-1:0] out_off_r, out_off_nxt;

  node_t                ram_rdata, node;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  node_t                ram_wdata;

  logic [SIZE_W-1:0]    len_sat, start, left, new_off;
  logic [SIZE_W:0]      dend;
  logic                 fit, split, hit, last;

  ffca_node_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // head node reads from registers until its first write
  always_comb begin
    node = ram_rdata;
    if (fresh_r && cur_r == '0) begin
      node.offset = '0;
      node.size   = head_size_r;
      node.used   = 1'b0;
      node.next   = END_MARK;
    end
  end

  assign start   = {1'b0, node.offset} + HDR_SZ;
  assign dend    = {1'b0, start} + {1'b0, node.size};
  assign left    = node.size - req_r;
  assign new_off = start + req_r;
  assign fit     = !node.used && node.size >= req_r;
  assign split   = left >= SPLIT_MIN && cnt_r < END_MARK;
  assign hit     = {1'b0, ptr_r} >= start && {2'b0, ptr_r} < dend;
  assign last    = node.next >= cnt_r;

  assign len_sat = (cfg_wr_data > ARENA_LIMIT) ? ARENA_LIMIT : cfg_wr_data;

  assign ram_raddr = (state_r == ST_WALK) ? node.next[IDX_W-1:0] : '0;
  assign ram_we    = (state_r == ST_WR_CUR) || (state_r == ST_WR_NEW);
  assign ram_waddr = (state_r == ST_WR_NEW) ? cnt_r[IDX_W-1:0] : cur_r;
  assign ram_wdata = (state_r == ST_WR_NEW) ? wnew_r : wcur_r;

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.data_offset = out_off_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    fresh_nxt      = fresh_r;
    head_size_nxt  = head_size_r;
    cur_nxt        = cur_r;
    cmd_nxt        = cmd_r;
    req_nxt        = req_r;
    ptr_nxt        = ptr_r;
    split_nxt      = split_r;
    wcur_nxt       = wcur_r;
    wnew_nxt       = wnew_r;
    res_status_nxt = res_status_r;
    res_off_nxt    = res_off_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_off_nxt    = out_off_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_wr_en) begin
      head_size_nxt = (len_sat >= HDR_SZ) ? len_sat - HDR_SZ : '0;
      fresh_nxt     = 1'b1;
      cnt_nxt       = NEXT_W'(1);
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt = in_ch.cmd;
          req_nxt = in_ch.request_size;
          ptr_nxt = in_ch.pointer_offset;
          cur_nxt = '0;
          if (in_ch.cmd == CMD_FREE && in_ch.pointer_is_null) begin
            res_status_nxt = STATUS_NULL;
            res_off_nxt    = '0;
            state_nxt      = ST_RESP;
          end else begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        split_nxt = 1'b0;
        res_off_nxt = '0;
        if (cmd_r == CMD_ALLOC && fit) begin
          res_status_nxt  = STATUS_OK;
          res_off_nxt     = start[ADDR_BITS-1:0];
          split_nxt       = split;
          wcur_nxt        = node;
          wcur_nxt.used   = 1'b1;
          if (split) begin
            wcur_nxt.size = req_r;
            wcur_nxt.next = cnt_r;
          end
          wnew_nxt.offset = new_off[ADDR_BITS-1:0];
          wnew_nxt.size   = left - HDR_SZ;
          wnew_nxt.used   = 1'b0;
          wnew_nxt.next   = node.next;
          state_nxt       = ST_WR_CUR;
        end else if (cmd_r == CMD_FREE && hit) begin
          wcur_nxt      = node;
          wcur_nxt.used = 1'b0;
          priority if ({1'b0, ptr_r} != start) begin
            res_status_nxt = STATUS_PARTIAL;
            state_nxt      = ST_RESP;
          end else if (!node.used) begin
            res_status_nxt = STATUS_DOUBLE_FREE;
            state_nxt      = ST_RESP;
          end else begin
            res_status_nxt = STATUS_OK;
            state_nxt      = ST_WR_CUR;
          end
        end else if (last) begin
          res_status_nxt = (cmd_r == CMD_ALLOC) ? STATUS_OOM : STATUS_NOT_FOUND;
          state_nxt      = ST_RESP;
        end else begin
          cur_nxt = node.next[IDX_W-1:0];
        end
      end
      ST_WR_CUR: begin
        if (cur_r == '0) begin
          fresh_nxt = 1'b0;
        end
        state_nxt = split_r ? ST_WR_NEW : ST_RESP;
      end
      ST_WR_NEW: begin
        cnt_nxt   = cnt_r + NEXT_W'(1);
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_off_nxt    = res_off_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= NEXT_W'(1);
      fresh_r     <= 1'b1;
      head_size_r <= HEAD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fresh_r     <= fresh_nxt;
      head_size_r <= head_size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    cmd_r        <= cmd_nxt;
    req_r        <= req_nxt;
    ptr_r        <= ptr_nxt;
    split_r      <= split_nxt;
    wcur_r       <= wcur_nxt;
    wnew_r       <= wnew_nxt;
    res_status_r <= res_status_nxt;
    res_off_r    <= res_off_nxt;
    out_status_r <= out_status_nxt;
    out_off_r    <= out_off_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r >= NEXT_W'(1) && cnt_r <= END_MARK)
    else $error("node count out of range");

  a_walk_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> {1'b0, cur_r} < cnt_r)
    else $error("walk index beyond node count");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(cfg_wr_en) && cnt_r != $past(cnt_r)
      |-> $past(state_r) == ST_WR_NEW && cnt_r == $past(cnt_r) + NEXT_W'(1))
    else $error("node count changed outside a split");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && out_valid_r && !$past(out_valid_r) |-> $past(state_r) == ST_RESP)
    else $error("result raised outside response state");

  a_split_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WR_NEW |-> cnt_r < END_MARK)
    else $error("split with full node table");

endmodule
`default_nettype wire
